// ===== rtl/core/satt_pkg.sv =====
// package for the set-associative top-k table
// types, constants and action codes; no dependencies
`timescale 1ns / 1ps
package satt_pkg;
  localparam int unsigned KeyW     = 32;
  localparam int unsigned EstW     = 31;
  localparam int unsigned DefBuckets = 1024;
  localparam int unsigned DefWays    = 4;

  typedef enum logic [1:0] {
    ActHit   = 2'd0,
    ActFree  = 2'd1,
    ActEvict = 2'd2,
    ActDrop  = 2'd3
  } action_e;

  // controller to datapath
  typedef struct packed {
    logic rd;    // read the bucket of the captured word
    logic wr;    // decide, write back and load the result register
  } satt_cmd_t;
endpackage

// ===== rtl/core/satt_if.sv =====
// valid/ready channel interfaces for the top-k table
// depends on satt_pkg
`timescale 1ns / 1ps
interface satt_in_if import satt_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [KeyW-1:0] key_hash;
  logic [EstW-1:0] estimate;
  modport source (output valid, key_hash, estimate, input ready);
  modport sink   (input valid, key_hash, estimate, output ready);
endinterface

interface satt_out_if import satt_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [1:0]      action;
  logic [KeyW-1:0] evicted_key;
  logic [EstW-1:0] evicted_estimate;
  modport source (output valid, action, evicted_key, evicted_estimate, input ready);
  modport sink   (input valid, action, evicted_key, evicted_estimate, output ready);
endinterface

// ===== rtl/core/satt_ctrl.sv =====
// controller for the top-k table: accept, read, decide, deliver
// depends on satt_pkg
`timescale 1ns / 1ps
module satt_ctrl import satt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      clr_busy_i,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output satt_cmd_t cmd_o
);
  typedef enum logic [0:0] {StIdle, StDecide} state_e;
  state_e state_q, state_d;
  logic   ovalid_q, ovalid_d;

  // next state and result flag
  always_comb begin
    state_d  = state_q;
    ovalid_d = ovalid_q;
    cmd_o    = '0;
    in_ready_o = 1'b0;
    if (ovalid_q && out_ready_i) ovalid_d = 1'b0;
    unique case (state_q)
      StIdle: begin
        // no word is taken while the bucket rows are being cleared
        in_ready_o = !clr_busy_i;
        if (in_valid_i && !clr_busy_i) begin
          cmd_o.rd = 1'b1;
          state_d  = StDecide;
        end
      end
      StDecide: begin
        // wait for the result register to be free
        if (!ovalid_q || out_ready_i) begin
          cmd_o.wr = 1'b1;
          ovalid_d = 1'b1;
          state_d  = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

  assign out_valid_o = ovalid_q;
endmodule

// ===== rtl/core/satt_dpath.sv =====
// datapath for the top-k table: bucket memory, valid bits, compare, result register
// depends on satt_pkg
`timescale 1ns / 1ps
module satt_dpath import satt_pkg::*; #(
  parameter int unsigned Buckets = DefBuckets,
  parameter int unsigned Ways    = DefWays
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  satt_cmd_t       cmd_i,
  input  logic [KeyW-1:0] key_hash_i,
  input  logic [EstW-1:0] estimate_i,
  output logic            clr_busy_o,
  output logic [1:0]      action_o,
  output logic [KeyW-1:0] evicted_key_o,
  output logic [EstW-1:0] evicted_estimate_o
);
  localparam int unsigned BktW = (Buckets > 1) ? $clog2(Buckets) : 1;
  localparam int unsigned WayW = (Ways > 1) ? $clog2(Ways) : 1;
  localparam logic [BktW-1:0] BktMask = BktW'(Buckets - 1);

  typedef struct packed {
    logic            vld;
    logic [KeyW-1:0] tag;
    logic [EstW-1:0] est;
  } entry_t;

  // one row per bucket, all ways side by side, valid bit kept with each way
  entry_t [Ways-1:0] mem_q [Buckets];
  entry_t [Ways-1:0] row_q, row_d;
  logic [KeyW-1:0]   key_q;
  logic [EstW-1:0]   est_q;
  logic [BktW-1:0]   bkt_in, bkt_q;
  logic [BktW-1:0]   clr_idx_q, clr_idx_d;
  logic              clr_busy_q, clr_busy_d;
  logic              hit, have_free, have_min, wen;
  logic [WayW-1:0]   hit_way, free_way, min_way, wway;
  logic [EstW-1:0]   min_est;
  action_e           act;

  assign bkt_in = key_hash_i[BktW-1:0] & BktMask;

  // clearing pass after reset, one bucket row per cycle
  always_comb begin
    clr_idx_d  = clr_idx_q;
    clr_busy_d = clr_busy_q;
    if (clr_busy_q) begin
      if (clr_idx_q == BktMask) clr_busy_d = 1'b0;
      else clr_idx_d = clr_idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_idx_q  <= '0;
      clr_busy_q <= 1'b1;
    end else begin
      clr_idx_q  <= clr_idx_d;
      clr_busy_q <= clr_busy_d;
    end
  end

  assign clr_busy_o = clr_busy_q;

  // capture the word and read its bucket
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      key_q  <= key_hash_i;
      est_q  <= estimate_i;
      bkt_q  <= bkt_in;
      row_q  <= mem_q[bkt_in];
    end
  end

  // hit, free and minimum search across the ways
  always_comb begin
    hit = 1'b0; hit_way = '0;
    have_free = 1'b0; free_way = '0;
    have_min = 1'b0; min_way = '0; min_est = '1;
    for (int w = 0; w < Ways; w++) begin
      if (row_q[w].vld) begin
        if (!hit && row_q[w].tag == key_q) begin
          hit = 1'b1; hit_way = WayW'(w);
        end
        if (!have_min || row_q[w].est < min_est) begin
          have_min = 1'b1; min_est = row_q[w].est; min_way = WayW'(w);
        end
      end else if (!have_free) begin
        have_free = 1'b1; free_way = WayW'(w);
      end
    end
    if (hit) begin
      act = ActHit; wway = hit_way; wen = 1'b1;
    end else if (have_free) begin
      act = ActFree; wway = free_way; wen = 1'b1;
    end else if (!have_min || est_q <= min_est) begin
      act = ActDrop; wway = '0; wen = 1'b0;
    end else begin
      act = ActEvict; wway = min_way; wen = 1'b1;
    end
    // updated row for write back
    row_d = row_q;
    if (wen) begin
      row_d[wway].vld = 1'b1;
      row_d[wway].tag = key_q;
      row_d[wway].est = est_q;
    end
  end

  // bucket memory write: clearing pass or write back
  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      mem_q[clr_idx_q] <= '0;
    end else if (cmd_i.wr && wen) begin
      mem_q[bkt_q] <= row_d;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      action_o <= act;
      if (act == ActEvict) begin
        evicted_key_o      <= row_q[min_way].tag;
        evicted_estimate_o <= row_q[min_way].est;
      end else begin
        evicted_key_o      <= '0;
        evicted_estimate_o <= '0;
      end
    end
  end
endmodule

// ===== rtl/core/set_assoc_topk_table.sv =====
// top level of the set-associative top-k table
// depends on satt_pkg, satt_if, satt_ctrl, satt_dpath
//
//  channel  dir  payload
//  in_if    in   key_hash, estimate
//  out_if   out  action, evicted_key, evicted_estimate
//
// each word goes through a bucket read, then decide and write back
// a new word is accepted while the previous result waits in the output register
// reset clears the control state; then a clearing pass empties every bucket row
// (Buckets rows, 1024 by default), with the input not ready meanwhile
// a stalled result holds the decide step until the output register frees
`timescale 1ns / 1ps
module set_assoc_topk_table import satt_pkg::*; #(
  parameter int unsigned Buckets = DefBuckets,
  parameter int unsigned Ways    = DefWays
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  satt_in_if.sink     in_if,
  satt_out_if.source  out_if
);
  satt_cmd_t  cmd;
  logic [1:0] action;
  logic       clr_busy;

  satt_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .clr_busy_i (clr_busy),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .out_valid_o(out_if.valid),
    .out_ready_i(out_if.ready),
    .cmd_o      (cmd)
  );

  satt_dpath #(.Buckets(Buckets), .Ways(Ways)) u_dpath (
    .clk_i, .rst_ni,
    .cmd_i             (cmd),
    .key_hash_i        (in_if.key_hash),
    .estimate_i        (in_if.estimate),
    .clr_busy_o        (clr_busy),
    .action_o          (action),
    .evicted_key_o     (out_if.evicted_key),
    .evicted_estimate_o(out_if.evicted_estimate)
  );

  assign out_if.action = action;
endmodule

// ===== rtl/core/satt_checker.sv =====
// port-level checks for the top-k table, bound to the top level
// depends on satt_pkg
`timescale 1ns / 1ps
module satt_checker import satt_pkg::*; (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_ready_i,
  input logic            out_valid_i,
  input logic            out_ready_i,
  input logic [1:0]      action_i,
  input logic [KeyW-1:0] evicted_key_i,
  input logic [EstW-1:0] evicted_estimate_i
);
  // a non-evicting result carries zero payload
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && action_i != ActEvict |-> evicted_key_i == '0 && evicted_estimate_i == '0)
    else $error("nonzero eviction payload");
  // an accepted word is not followed by another accept next cycle
  a_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("accept two cycles in a row");
  // a result stays until taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(action_i))
    else $error("result dropped");
endmodule

bind set_assoc_topk_table satt_checker u_satt_checker (
  .clk_i, .rst_ni,
  .in_valid_i(in_if.valid), .in_ready_i(in_if.ready),
  .out_valid_i(out_if.valid), .out_ready_i(out_if.ready),
  .action_i(out_if.action), .evicted_key_i(out_if.evicted_key),
  .evicted_estimate_i(out_if.evicted_estimate)
);

// ===== verif/satt_scoreboard.sv =====
// checker for the set-associative top-k table: watches both channels,
// predicts each result word and compares it; depends on satt_pkg and satt_if
`timescale 1ns / 1ps
module satt_scoreboard import satt_pkg::*; #(
  parameter int unsigned Buckets = DefBuckets,
  parameter int unsigned Ways    = DefWays
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  satt_in_if        in_if,
  satt_out_if       out_if,
  output int        fail_cnt_o,
  output int        pending_o
);
  localparam int unsigned Entries = Buckets * Ways;

  typedef struct {
    action_e         act;
    logic [KeyW-1:0] key;
    logic [EstW-1:0] est;
  } outcome_t;

  logic [KeyW-1:0] tag_mem [Entries];
  logic [EstW-1:0] est_mem [Entries];
  bit              vld_mem [Entries];
  outcome_t        outcome_q[$];

  assign pending_o = outcome_q.size();

  task automatic report(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    fail_cnt_o++;
  endtask

  // table update for one accepted word
  function automatic outcome_t predict_table(input logic [KeyW-1:0] key,
                                             input logic [EstW-1:0] est);
    outcome_t o;
    int unsigned base;
    int free_w;
    int min_w;
    logic [EstW-1:0] min_e;
    bit have_min;
    base = (key & (Buckets - 1)) * Ways;
    free_w = -1;
    min_w = 0;
    min_e = '1;
    have_min = 0;
    o.act = ActHit;
    o.key = '0;
    o.est = '0;
    for (int w = 0; w < Ways; w++) begin
      if (vld_mem[base+w]) begin
        if (tag_mem[base+w] == key) begin
          est_mem[base+w] = est;
          return o;
        end
        if (!have_min || est_mem[base+w] < min_e) begin
          have_min = 1;
          min_e = est_mem[base+w];
          min_w = w;
        end
      end else if (free_w < 0) begin
        free_w = w;
      end
    end
    if (free_w >= 0) begin
      tag_mem[base+free_w] = key;
      est_mem[base+free_w] = est;
      vld_mem[base+free_w] = 1;
      o.act = ActFree;
    end else if (est <= min_e) begin
      o.act = ActDrop;
    end else begin
      o.act = ActEvict;
      o.key = tag_mem[base+min_w];
      o.est = est_mem[base+min_w];
      tag_mem[base+min_w] = key;
      est_mem[base+min_w] = est;
    end
    return o;
  endfunction

  initial begin
    fail_cnt_o = 0;
    for (int i = 0; i < Entries; i++) vld_mem[i] = 0;
  end

  // sample both channels at the edge
  always @(posedge clk_i) begin
    outcome_t exp_o;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        if (outcome_q.size() == 0) begin
          report("result word with nothing expected");
        end else begin
          exp_o = outcome_q.pop_front();
          if (out_if.action !== exp_o.act)
            report($sformatf("action %0d, expected %0d", out_if.action, exp_o.act));
          if (out_if.evicted_key !== exp_o.key)
            report($sformatf("evicted_key %h, expected %h", out_if.evicted_key, exp_o.key));
          if (out_if.evicted_estimate !== exp_o.est)
            report($sformatf("evicted_estimate %h, expected %h",
                             out_if.evicted_estimate, exp_o.est));
        end
      end
      if (in_if.valid && in_if.ready)
        outcome_q.insert(outcome_q.size(), predict_table(in_if.key_hash, in_if.estimate));
    end
  end
endmodule

// ===== verif/set_assoc_topk_table_tb.sv =====
// testbench top for the set-associative top-k table: drives keyed words
// with random gaps and stalls; depends on satt_pkg, satt_if, satt_scoreboard, set_assoc_topk_table
`timescale 1ns / 1ps
module set_assoc_topk_table_tb;
  import satt_pkg::*;

  logic clk_i = 0;
  logic rst_ni = 0;
  int   fail_cnt;
  int   pending;
  bit   no_idle = 0;

  satt_in_if  in_if ();
  satt_out_if out_if ();

  set_assoc_topk_table uut (.clk_i(clk_i), .rst_ni(rst_ni), .in_if(in_if), .out_if(out_if));
  satt_scoreboard sb (.clk_i(clk_i), .rst_ni(rst_ni), .in_if(in_if), .out_if(out_if),
                      .fail_cnt_o(fail_cnt), .pending_o(pending));

  always #5 clk_i = ~clk_i;

  // result-side stalls
  initial out_if.ready = 0;
  always @(posedge clk_i) out_if.ready <= no_idle || ($urandom_range(99) >= 38);

  // one word, with a random gap before it; valid drops only during a gap
  task automatic send_word(input logic [KeyW-1:0] key, input logic [EstW-1:0] est);
    while (!no_idle && $urandom_range(99) < 38) begin
      in_if.valid <= 0;
      @(posedge clk_i);
    end
    in_if.valid    <= 1;
    in_if.key_hash <= key;
    in_if.estimate <= est;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  // hot keys in a few buckets so the ways fill, hit and evict
  function automatic logic [KeyW-1:0] pick_key();
    logic [KeyW-1:0] k;
    k = $urandom;
    case ($urandom_range(3))
      0: k[9:0] = 10'($urandom_range(7));
      1: k = {4'($urandom_range(15)), 18'h0, 10'($urandom_range(3))};
      2: k[9:0] = 10'h3ff;
      default: ;
    endcase
    return k;
  endfunction

  function automatic logic [EstW-1:0] pick_est();
    case ($urandom_range(3))
      0: return EstW'($urandom_range(20));
      1: return EstW'($urandom >> 1);
      2: return EstW'(32'h7fffffff - $urandom_range(3));
      default: return EstW'($urandom_range(5000));
    endcase
  endfunction

  initial begin
    int waited;
    in_if.valid = 0;
    in_if.key_hash = '0;
    in_if.estimate = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: fill bucket zero, hit, tie drop, evict, extremes
    send_word(32'h0000_0000, 31'h0);
    send_word(32'h0000_0400, 31'd5);
    send_word(32'h0000_0800, 31'd5);
    send_word(32'hffff_fc00, 31'h7fffffff);
    send_word(32'h0000_0400, 31'd3);
    send_word(32'h0000_0c00, 31'd0);
    send_word(32'h0000_1000, 31'd1);
    send_word(32'h0000_1400, 31'd3);
    send_word(32'h0000_1800, 31'd4);
    send_word(32'hffff_ffff, 31'h7fffffff);
    send_word(32'hffff_ffff, 31'h0);
    send_word(32'h7fff_ffff, 31'h2aaaaaaa);
    send_word(32'hbfff_ffff, 31'h55555555);
    send_word(32'hdfff_ffff, 31'h1);
    send_word(32'hefff_ffff, 31'h0);
    send_word(32'haaaa_aaaa, 31'h7ffffffe);
    send_word(32'h5555_5555, 31'h7fffffff);
    in_if.valid <= 0;
    @(posedge clk_i);

    // sender holds until the table has drained
    while (pending != 0) @(posedge clk_i);

    for (int n = 0; n < 900; n++) begin
      no_idle = (n >= 300 && n < 420);
      send_word(pick_key(), pick_est());
    end
    no_idle = 0;
    in_if.valid <= 0;

    waited = 0;
    while (pending != 0 && waited < 100000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (10) @(posedge clk_i);
    if (fail_cnt == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Test completed with failures");
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/core/satt_pkg.sv
rtl/core/satt_if.sv
rtl/core/satt_ctrl.sv
rtl/core/satt_dpath.sv
rtl/core/set_assoc_topk_table.sv
rtl/core/satt_checker.sv
verif/satt_scoreboard.sv
verif/set_assoc_topk_table_tb.sv
